[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros
// Assertion macros used by mie_back. Simulation sees the checks,
// synthesis sees nothing.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define MIE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define MIE_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define MIE_ASSERT(lbl, clk, rst, prop)
`define MIE_NEVER(lbl, clk, rst, cond)
`endif

`endif

[src/mie_pkg.sv]
// ---------------------------------------------------------------------------
// mie_pkg
// Shared constants and the command type passed from front to back.
// ---------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

   localparam int MAX_LISTS     = 8;
   localparam int LIST_CAPACITY = 32;
   localparam int MAX_RESULTS   = 32;
   localparam int ELEM_W        = 32;
   localparam int QUEUE_DEPTH   = 2;

   localparam int LIST_W  = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
   localparam int CNT_W   = $clog2(LIST_CAPACITY + 1);
   localparam int LCNT_W  = $clog2(MAX_LISTS + 1);
   localparam int RES_W   = $clog2(MAX_RESULTS + 1);
   localparam int DEPTH   = MAX_LISTS * LIST_CAPACITY;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              is_finish;
      logic              in_range;
      logic [LIST_W-1:0] list;
      logic [ELEM_W-1:0] element;
      logic [LCNT_W-1:0] lists;
   } cmd_type;

endpackage

`default_nettype wire

[src/mie_ram.sv]
// ---------------------------------------------------------------------------
// mie_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/mie_front.sv]
// ---------------------------------------------------------------------------
// mie_front
// Accept request transactions, classify them and queue them for the back.
// ---------------------------------------------------------------------------
`default_nettype none

module mie_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_action,
   input  wire logic [2:0]                    req_list_index,
   input  wire logic [31:0]                   req_element,
   input  wire logic [3:0]                    req_list_count,
   output logic                               q_valid,
   output mie_pkg::cmd_type                   q_cmd,
   input  wire logic                          q_pop
);

   mie_pkg::cmd_type                     slot_ff [mie_pkg::QUEUE_DEPTH];
   logic [mie_pkg::QPTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [mie_pkg::QPTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [mie_pkg::QCNT_W-1:0]           cnt_ff, cnt_in;
   mie_pkg::cmd_type                     cmd;
   logic                                 push;
   logic                                 pop;

   // classify the incoming transaction
   always_comb begin
      cmd.is_finish = req_action;
      cmd.in_range  = (32'(req_list_index) < mie_pkg::MAX_LISTS);
      cmd.list      = mie_pkg::LIST_W'(req_list_index);
      cmd.element   = req_element;
      if (32'(req_list_count) > mie_pkg::MAX_LISTS) begin
         cmd.lists = mie_pkg::LCNT_W'(mie_pkg::MAX_LISTS);
      end else begin
         cmd.lists = mie_pkg::LCNT_W'(req_list_count);
      end
   end

   assign req_ready = (cnt_ff != mie_pkg::QCNT_W'(mie_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_cmd     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mie_pkg::QPTR_W'(mie_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mie_pkg::QPTR_W'(mie_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

`default_nettype wire

[src/mie_back.sv]
// ---------------------------------------------------------------------------
// mie_back
// Execute queued commands: store elements, walk the lists on finish and
// drive the result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mie_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire mie_pkg::cmd_type  q_cmd,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [31:0]            rsp_value,
   output logic                   rsp_empty_res,
   output logic                   rsp_dropped,
   output logic                   rsp_last
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN0 = 5'b00010,
      ST_SCANL = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   localparam int LW = mie_pkg::LIST_W;
   localparam int CW = mie_pkg::CNT_W;
   localparam int AW = mie_pkg::ADDR_W;
   localparam int EW = mie_pkg::ELEM_W;

   state_type             st_ff, st_in;
   logic [CW-1:0]         fill_ff [mie_pkg::MAX_LISTS];
   logic [CW-1:0]         fill_in [mie_pkg::MAX_LISTS];
   logic                  ovf_ff, ovf_in;
   logic [mie_pkg::LCNT_W-1:0] lists_ff, lists_in;
   logic [mie_pkg::LCNT_W-1:0] cur_l_ff, cur_l_in;
   logic [CW-1:0]         rd_idx_ff, rd_idx_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic                  first_ff, first_in;
   logic [EW-1:0]         prev_ff, prev_in;
   logic                  found_ff, found_in;
   logic [EW-1:0]         min_ff, min_in;
   logic [CW-1:0]         mcnt_ff, mcnt_in;
   logic [CW-1:0]         freq_ff, freq_in;
   logic [CW-1:0]         lcnt_ff, lcnt_in;
   logic [mie_pkg::RES_W-1:0] nres_ff, nres_in;
   logic                  hold_valid_ff, hold_valid_in;
   logic [EW-1:0]         hold_ff, hold_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [EW-1:0]         rsp_value_ff, rsp_value_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_dropped_ff, rsp_dropped_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [LW-1:0]         fill_sel;
   logic [CW-1:0]         cur_fill;
   logic                  scan_active;
   logic                  issue;
   logic                  scan_done;
   logic                  out_free;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [EW-1:0]         rd_data;
   logic                  cand;

   // one read port on the fill counts: add target, list 0, or list in scan
   always_comb begin
      priority if (st_ff == ST_IDLE) begin
         fill_sel = q_cmd.list;
      end else if (st_ff == ST_SCAN0) begin
         fill_sel = '0;
      end else begin
         fill_sel = cur_l_ff[LW-1:0];
      end
   end
   assign cur_fill = fill_ff[fill_sel];

   assign scan_active = (st_ff == ST_SCAN0) ||
                        ((st_ff == ST_SCANL) && (cur_l_ff != lists_ff) && (freq_ff != '0));
   assign issue       = scan_active && (rd_idx_ff < cur_fill);
   assign scan_done   = scan_active && !issue && !rd_pend_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign rd_addr     = AW'(AW'(fill_sel) * AW'(mie_pkg::LIST_CAPACITY) + AW'(rd_idx_ff));
   assign wr_addr     = AW'(AW'(fill_sel) * AW'(mie_pkg::LIST_CAPACITY) + AW'(cur_fill));
   assign cand        = first_ff || (rd_data > prev_ff);

   always_comb begin
      st_in          = st_ff;
      fill_in        = fill_ff;
      ovf_in         = ovf_ff;
      lists_in       = lists_ff;
      cur_l_in       = cur_l_ff;
      rd_idx_in      = rd_idx_ff;
      rd_pend_in     = issue;
      first_in       = first_ff;
      prev_in        = prev_ff;
      found_in       = found_ff;
      min_in         = min_ff;
      mcnt_in        = mcnt_ff;
      freq_in        = freq_ff;
      lcnt_in        = lcnt_ff;
      nres_in        = nres_ff;
      hold_valid_in  = hold_valid_ff;
      hold_in        = hold_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_value_in   = rsp_value_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_last_in    = rsp_last_ff;
      q_pop          = 1'b0;
      wr_en          = 1'b0;

      if (issue) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end

      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (!q_cmd.is_finish) begin
                  if (q_cmd.in_range) begin
                     if (cur_fill < CW'(mie_pkg::LIST_CAPACITY)) begin
                        wr_en             = 1'b1;
                        fill_in[fill_sel] = cur_fill + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
               end else begin
                  lists_in      = q_cmd.lists;
                  nres_in       = '0;
                  hold_valid_in = 1'b0;
                  first_in      = 1'b1;
                  found_in      = 1'b0;
                  mcnt_in       = '0;
                  rd_idx_in     = '0;
                  st_in         = (q_cmd.lists == '0) ? ST_FLUSH : ST_SCAN0;
               end
            end
         end
         ST_SCAN0: begin
            // smallest value of list 0 above the previous one, and its count
            if (rd_pend_ff && cand) begin
               if (!found_ff || (rd_data < min_ff)) begin
                  found_in = 1'b1;
                  min_in   = rd_data;
                  mcnt_in  = CW'(1);
               end else if (rd_data == min_ff) begin
                  mcnt_in = mcnt_ff + 1'b1;
               end
            end
            if (scan_done) begin
               if (!found_ff) begin
                  st_in = ST_FLUSH;
               end else begin
                  prev_in   = min_ff;
                  first_in  = 1'b0;
                  freq_in   = mcnt_ff;
                  cur_l_in  = mie_pkg::LCNT_W'(1);
                  rd_idx_in = '0;
                  lcnt_in   = '0;
                  st_in     = ST_SCANL;
               end
            end
         end
         ST_SCANL: begin
            if (!scan_active) begin
               rd_idx_in = '0;
               found_in  = 1'b0;
               mcnt_in   = '0;
               st_in     = (freq_ff != '0) ? ST_EMIT : ST_SCAN0;
            end else begin
               if (rd_pend_ff && (rd_data == prev_ff)) begin
                  lcnt_in = lcnt_ff + 1'b1;
               end
               if (scan_done) begin
                  if (lcnt_ff < freq_ff) begin
                     freq_in = lcnt_ff;
                  end
                  cur_l_in  = cur_l_ff + 1'b1;
                  rd_idx_in = '0;
                  lcnt_in   = '0;
               end
            end
         end
         ST_EMIT: begin
            // hold one result back so the final one can carry last
            if (!hold_valid_ff || out_free) begin
               if (hold_valid_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_value_in   = hold_ff;
                  rsp_empty_in   = 1'b0;
                  rsp_dropped_in = ovf_ff;
                  rsp_last_in    = 1'b0;
               end
               hold_valid_in = 1'b1;
               hold_in       = prev_ff;
               nres_in       = nres_ff + 1'b1;
               freq_in       = freq_ff - 1'b1;
               priority if (nres_ff == mie_pkg::RES_W'(mie_pkg::MAX_RESULTS - 1)) begin
                  st_in = ST_FLUSH;
               end else if (freq_ff == CW'(1)) begin
                  st_in = ST_SCAN0;
               end else begin
                  st_in = ST_EMIT;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_value_in   = hold_valid_ff ? hold_ff : '0;
               rsp_empty_in   = !hold_valid_ff;
               rsp_dropped_in = ovf_ff;
               rsp_last_in    = 1'b1;
               hold_valid_in  = 1'b0;
               ovf_in         = 1'b0;
               for (int i = 0; i < mie_pkg::MAX_LISTS; i++) begin
                  fill_in[i] = '0;
               end
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_IDLE;
         ovf_ff        <= 1'b0;
         rd_pend_ff    <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         nres_ff       <= '0;
         for (int i = 0; i < mie_pkg::MAX_LISTS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         st_ff         <= st_in;
         ovf_ff        <= ovf_in;
         rd_pend_ff    <= rd_pend_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         nres_ff       <= nres_in;
         fill_ff       <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      lists_ff       <= lists_in;
      cur_l_ff       <= cur_l_in;
      rd_idx_ff      <= rd_idx_in;
      first_ff       <= first_in;
      prev_ff        <= prev_in;
      found_ff       <= found_in;
      min_ff         <= min_in;
      mcnt_ff        <= mcnt_in;
      freq_ff        <= freq_in;
      lcnt_ff        <= lcnt_in;
      hold_ff        <= hold_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_last_ff    <= rsp_last_in;
   end

   mie_ram #(
      .WIDTH (EW),
      .DEPTH (mie_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (q_cmd.element),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_dropped   = rsp_dropped_ff;
   assign rsp_last      = rsp_last_ff;

   `MIE_NEVER(a_nres_bound, clock, reset, nres_ff > mie_pkg::RES_W'(mie_pkg::MAX_RESULTS))
   `MIE_ASSERT(a_pend_from_scan, clock, reset, rd_pend_ff |-> ($past(st_ff == ST_SCAN0) || $past(st_ff == ST_SCANL)))
   `MIE_NEVER(a_emit_nonzero, clock, reset, (st_ff == ST_EMIT) && (freq_ff == '0))
   `MIE_ASSERT(a_flush_last, clock, reset, ((st_ff == ST_FLUSH) && out_free) |=> (rsp_valid_ff && rsp_last_ff))

endmodule

`default_nettype wire

[src/multiset_intersection_engine.sv]
// ---------------------------------------------------------------------------
// multiset_intersection_engine
// Loads up to eight element lists and emits their multiset intersection.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per item. An add (req_action low) appends
//   req_element to list req_list_index; a full list drops it and sets the
//   dropped flag. A finish (req_action high) takes lists 0 .. req_list_count-1,
//   capped at list 7, and emits their intersection on rsp_* in ascending order,
//   one value per transaction, the final one marked by rsp_last. An empty
//   intersection gives a single transaction with rsp_empty_res set and
//   rsp_value zero. At most 32 results are produced per finish.
// Flow:
//   Adds are taken one per cycle through a two-entry queue while no finish
//   is being walked. A finish walks the element store through its single
//   read port: for every distinct value of list 0 one pass over list 0, then
//   one pass over each other list while the value survives, then its results
//   are emitted; the last result is loaded in the flush state. Requests
//   queue behind a finish until its last result is loaded.
// Reset clears the fill counts, dropped flag, queue and result register; no
//   clearing pass is needed. A stalled receiver holds the result register
//   and the walk pauses at the next emission.
// ---------------------------------------------------------------------------
`default_nettype none

module multiset_intersection_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_action,
   input  wire logic [2:0]  req_list_index,
   input  wire logic [31:0] req_element,
   input  wire logic [3:0]  req_list_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_value,
   output logic             rsp_empty_res,
   output logic             rsp_dropped,
   output logic             rsp_last
);

   // queue between front and back
   logic             q_valid;
   logic             q_pop;
   mie_pkg::cmd_type q_cmd;

   // front: accept and classify transactions
   mie_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_list_index (req_list_index),
      .req_element    (req_element),
      .req_list_count (req_list_count),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .q_pop          (q_pop)
   );

   // back: store, walk and emit
   mie_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (q_cmd),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_empty_res (rsp_empty_res),
      .rsp_dropped   (rsp_dropped),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

[bench/tb.sv]
// ---------------------------------------------------------------------------
// Multiset intersection engine testbench
// Loads element lists through the request channel, issues finish
// transactions and checks every response against a behavioural predictor of
// the multiset intersection, under several idling and back-pressure phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;

   localparam logic ACT_ADD    = 1'b0;
   localparam logic ACT_FINISH = 1'b1;
   localparam int   CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [31:0] value;
      logic        empty_res;
      logic        dropped;
      logic        last;
   } rsp_item_type;

   typedef struct {
      logic         action;
      logic [2:0]   list_index;
      logic [31:0]  element;
      logic [3:0]   list_count;
      logic         typed;     // expected response written in the table
      rsp_item_type want;      // single typed-in response
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = 1'b0;
   logic [2:0] req_list_index = '0;
   logic [31:0] req_element = '0;
   logic [3:0] req_list_count = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_value;
   logic rsp_empty_res, rsp_dropped, rsp_last;

   multiset_intersection_engine DUT (.*);

   // Predictor state: the engine's lists as seen from outside
   logic [31:0] lists_held [mie_pkg::MAX_LISTS][mie_pkg::LIST_CAPACITY];
   int unsigned fill_level [mie_pkg::MAX_LISTS];
   logic        capacity_overflow;

   rsp_item_type intersection_q[$];
   int      errors = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   bit      hold_off = 1'b0;
   bit      stimulus_done = 1'b0;
   longint  cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Compute the expected responses for one accepted transaction
   task automatic predict_transaction(input logic act, input logic [2:0] idx,
                                      input logic [31:0] elem,
                                      input logic [3:0] cnt);
      int unsigned n_lists, n0, i, j, l, mult, c, produced;
      logic [31:0] sorted0 [mie_pkg::LIST_CAPACITY];
      logic [31:0] v, t;
      rsp_item_type r;
      produced = 0;
      if (act == ACT_ADD) begin
         if (idx < mie_pkg::MAX_LISTS) begin
            if (fill_level[idx] < mie_pkg::LIST_CAPACITY) begin
               lists_held[idx][fill_level[idx]] = elem;
               fill_level[idx]++;
            end else begin
               capacity_overflow = 1'b1;
            end
         end
         return;
      end
      n_lists = (cnt > mie_pkg::MAX_LISTS) ? mie_pkg::MAX_LISTS : cnt;
      if (n_lists > 0) begin
         n0 = fill_level[0];
         for (i = 0; i < n0; i++) sorted0[i] = lists_held[0][i];
         for (i = 1; i < n0; i++) begin
            for (j = i; j > 0 && sorted0[j-1] > sorted0[j]; j--) begin
               t = sorted0[j]; sorted0[j] = sorted0[j-1]; sorted0[j-1] = t;
            end
         end
         i = 0;
         while (i < n0 && produced < mie_pkg::MAX_RESULTS) begin
            v = sorted0[i];
            mult = 0;
            while (i < n0 && sorted0[i] == v) begin
               mult++; i++;
            end
            for (l = 1; l < n_lists && mult > 0; l++) begin
               c = 0;
               for (j = 0; j < fill_level[l]; j++) if (lists_held[l][j] == v) c++;
               if (c < mult) mult = c;
            end
            for (j = 0; j < mult && produced < mie_pkg::MAX_RESULTS; j++) begin
               r = '{value: v, empty_res: 1'b0, dropped: capacity_overflow, last: 1'b0};
               intersection_q = {intersection_q, r};
               produced++;
            end
         end
      end
      if (produced == 0) begin
         r = '{value: 32'd0, empty_res: 1'b1, dropped: capacity_overflow, last: 1'b1};
         intersection_q = {intersection_q, r};
      end else begin
         intersection_q[$].last = 1'b1;
      end
      for (i = 0; i < mie_pkg::MAX_LISTS; i++) fill_level[i] = 0;
      capacity_overflow = 1'b0;
   endtask

   // Offer one transaction and hold it until accepted; valid stays high
   // afterwards so the next offer can follow without a gap
   task automatic offer(input logic act, input logic [2:0] idx,
                        input logic [31:0] elem, input logic [3:0] cnt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_list_index <= idx;
      req_element    <= elem;
      req_list_count <= cnt;
      do @(posedge clock); while (!req_ready);
      predict_transaction(act, idx, elem, cnt);
   endtask

   // Drop valid after the last accepted transaction of a sequence
   task automatic release_request();
      req_valid <= 1'b0;
   endtask

   task automatic finish_and_drain(input logic [3:0] cnt);
      offer(ACT_FINISH, 3'd0, 32'd0, cnt);
      release_request();
      while (intersection_q.size() != 0) @(posedge clock);
   endtask

   // Random well-formed set: a common pool spread over several lists
   task automatic random_set();
      int unsigned n_lists, l, k, n;
      logic [31:0] pool [6];
      for (k = 0; k < 6; k++)
         pool[k] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(9);
      n_lists = $urandom_range(mie_pkg::MAX_LISTS, 1);
      for (l = 0; l < n_lists; l++) begin
         n = $urandom_range(6);
         for (k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0)
               offer(ACT_ADD, 3'($urandom), $urandom, 4'($urandom));
            else
               offer(ACT_ADD, 3'(l), pool[$urandom_range(5)], 4'($urandom));
         end
      end
      if ($urandom_range(7) == 0) finish_and_drain(4'($urandom));
      else finish_and_drain(4'(n_lists));
   endtask

   stim_row_type directed [] = '{
      // finish straight after reset: empty result, nothing dropped
      '{ACT_FINISH, 3'd0, 32'd0, 4'd1, 1'b1, '{32'd0, 1'b1, 1'b0, 1'b1}},
      // count zero with data present: still empty
      '{ACT_ADD,    3'd0, 32'hFFFFFFFF, 4'd15, 1'b0, '0},
      '{ACT_FINISH, 3'd7, 32'hFFFFFFFF, 4'd0, 1'b1, '{32'd0, 1'b1, 1'b0, 1'b1}},
      // single list, extremes, unsorted arrival
      '{ACT_ADD,    3'd0, 32'hFFFFFFFF, 4'd0, 1'b0, '0},
      '{ACT_ADD,    3'd0, 32'h00000000, 4'd0, 1'b0, '0},
      '{ACT_ADD,    3'd0, 32'h80000000, 4'd0, 1'b0, '0},
      '{ACT_FINISH, 3'd0, 32'd0, 4'd1, 1'b0, '0},
      // two lists with repeats: minimum multiplicity
      '{ACT_ADD,    3'd0, 32'd5, 4'd0, 1'b0, '0},
      '{ACT_ADD,    3'd0, 32'd5, 4'd0, 1'b0, '0},
      '{ACT_ADD,    3'd0, 32'd3, 4'd0, 1'b0, '0},
      '{ACT_ADD,    3'd1, 32'd5, 4'd0, 1'b0, '0},
      '{ACT_ADD,    3'd1, 32'd3, 4'd0, 1'b0, '0},
      '{ACT_ADD,    3'd1, 32'd3, 4'd0, 1'b0, '0},
      '{ACT_FINISH, 3'd0, 32'd0, 4'd2, 1'b0, '0},
      // disjoint lists, count above the list limit saturates
      '{ACT_ADD,    3'd0, 32'd1, 4'd0, 1'b0, '0},
      '{ACT_ADD,    3'd7, 32'd2, 4'd0, 1'b0, '0},
      '{ACT_FINISH, 3'd0, 32'd0, 4'd15, 1'b1, '{32'd0, 1'b1, 1'b0, 1'b1}},
      // list 1 missing from a two-list finish: empty
      '{ACT_ADD,    3'd0, 32'hA5A5A5A5, 4'd0, 1'b0, '0},
      '{ACT_FINISH, 3'd0, 32'd0, 4'd2, 1'b1, '{32'd0, 1'b1, 1'b0, 1'b1}}
   };

   // Response checker and ready driver
   always @(posedge clock) begin
      rsp_item_type got, exp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_value, rsp_empty_res, rsp_dropped, rsp_last};
            if (intersection_q.size() == 0) begin
               $error("unexpected response value %h", got.value);
               errors++;
            end else begin
               exp = intersection_q.pop_front();
               if (got.value !== exp.value) begin
                  $error("value: expected %h, got %h", exp.value, got.value); errors++;
               end
               if (got.empty_res !== exp.empty_res) begin
                  $error("empty_res: expected %b, got %b", exp.empty_res, got.empty_res);
                  errors++;
               end
               if (got.dropped !== exp.dropped) begin
                  $error("dropped: expected %b, got %b", exp.dropped, got.dropped); errors++;
               end
               if (got.last !== exp.last) begin
                  $error("last: expected %b, got %b", exp.last, got.last); errors++;
               end
            end
         end
         rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Long receiver hold-off while the sender keeps loading a full list
   task automatic back_pressure_burst();
      int k;
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            for (k = 0; k < 34; k++) offer(ACT_ADD, 3'd0, 32'($urandom_range(40)), 4'd0);
            offer(ACT_FINISH, 3'd0, 32'd0, 4'd1);
            for (k = 0; k < 4; k++) offer(ACT_ADD, 3'd1, 32'(k), 4'd0);
            offer(ACT_FINISH, 3'd0, 32'd0, 4'd2);
            release_request();
         end
      join
      while (intersection_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      int r, p, i;
      int phase_idle [4] = '{0, 63, 0, 14};
      int phase_stall[4] = '{0, 0, 63, 14};
      for (i = 0; i < mie_pkg::MAX_LISTS; i++) fill_level[i] = 0;
      capacity_overflow = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows; typed rows also check the predictor's own answer
      for (r = 0; r < directed.size(); r++) begin
         if (directed[r].typed) begin
            offer(directed[r].action, directed[r].list_index, directed[r].element,
                  directed[r].list_count);
            release_request();
            if (intersection_q.size() != 1 || intersection_q[0] != directed[r].want) begin
               $error("row %0d: table and predictor disagree", r);
               errors++;
            end
            while (intersection_q.size() != 0) @(posedge clock);
         end else if (directed[r].action == ACT_FINISH) begin
            finish_and_drain(directed[r].list_count);
         end else begin
            offer(directed[r].action, directed[r].list_index, directed[r].element,
                  directed[r].list_count);
         end
      end

      // Overflow: thirty-four into one list, then the result set dropped
      back_pressure_burst();

      // One random set under each idling phase
      for (p = 0; p < 4; p++) begin
         send_idle_pct  = phase_idle[p];
         recv_stall_pct = phase_stall[p];
         random_set();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;

      while (intersection_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0 && intersection_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
